@@ hdl/qtd_pkg.sv @@
// Shared types and constants for the quadtree image decoder.
// No dependencies; imported by qtd_walk and quadtree_image_decoder.
package qtd_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int LEVEL_W     = 4;
    localparam int IDX_W       = 3;

    localparam logic [7:0] UNIFORM_FLAG = 8'd1;
    localparam logic [1:0] QUAD_LAST    = 2'd3;

    typedef logic [1:0] quad_t;

    typedef struct packed {
        logic                 valid;
        logic [7:0]           row;
        logic [7:0]           col;
        logic [LEVEL_W-1:0]   log_size;
        logic [7:0]           value;
        logic                 done;
    } fill_t;

    // log2 of the side, rounded down, capped at the stack depth
    function automatic int root_log(input int side);
        int l;
        l = 0;
        for (int k = 0; k < STACK_DEPTH; k++)
        begin
            if ((2 << k) <= side)
            begin
                l = k + 1;
            end
        end
        return l;
    endfunction

endpackage

@@ hdl/qtd_walk.sv @@
// Tree walker: quadrant stack, level and flag/value phase, one byte per step.
// Depends on qtd_pkg.
module qtd_walk
    import qtd_pkg::*;
#(
    parameter int ROOT_LOG = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] stream_byte,
    output fill_t      fill
);

    quad_t              stack_reg  [STACK_DEPTH];
    quad_t              stack_next [STACK_DEPTH];
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic               awaiting_reg;
    logic               awaiting_next;

    logic               open_found;
    logic [IDX_W-1:0]   open_idx;
    logic [7:0]         row;
    logic [7:0]         col;

    // deepest level that still has a quadrant left to visit
    always_comb
    begin
        open_found = 1'b0;
        open_idx   = '0;
        for (int k = 0; k < STACK_DEPTH; k++)
        begin
            if ((LEVEL_W'(k) < level_reg) && (stack_reg[k] != QUAD_LAST))
            begin
                open_found = 1'b1;
                open_idx   = IDX_W'(k);
            end
        end
    end

    always_comb
    begin
        row = '0;
        col = '0;
        for (int d = 0; d < STACK_DEPTH; d++)
        begin
            if ((d < ROOT_LOG) && (LEVEL_W'(d) < level_reg))
            begin
                row[IDX_W'(ROOT_LOG - 1 - d)] = stack_reg[d][1];
                col[IDX_W'(ROOT_LOG - 1 - d)] = stack_reg[d][0];
            end
        end
    end

    always_comb
    begin
        stack_next    = stack_reg;
        level_next    = level_reg;
        awaiting_next = awaiting_reg;

        fill.valid    = step && awaiting_reg;
        fill.row      = row;
        fill.col      = col;
        fill.log_size = LEVEL_W'(ROOT_LOG) - level_reg;
        fill.value    = stream_byte;
        fill.done     = !open_found;

        if (step)
        begin
            priority if (awaiting_reg || ((stream_byte != UNIFORM_FLAG) &&
                                          (level_reg >= LEVEL_W'(ROOT_LOG))))
            begin
                // value byte, or split at size one: move to next block
                awaiting_next = 1'b0;
                if (open_found)
                begin
                    level_next = LEVEL_W'(open_idx) + 1'b1;
                    for (int k = 0; k < STACK_DEPTH; k++)
                    begin
                        if (IDX_W'(k) == open_idx)
                        begin
                            stack_next[k] = stack_reg[k] + 1'b1;
                        end
                    end
                end
                else
                begin
                    level_next = '0;
                end
            end
            else if (stream_byte == UNIFORM_FLAG)
            begin
                awaiting_next = 1'b1;
            end
            else
            begin
                // split: descend into top-left quadrant
                level_next = level_reg + 1'b1;
                for (int k = 0; k < STACK_DEPTH; k++)
                begin
                    if (IDX_W'(k) == level_reg[IDX_W-1:0])
                    begin
                        stack_next[k] = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STACK_DEPTH; k++)
            begin
                stack_reg[k] <= '0;
            end
            level_reg    <= '0;
            awaiting_reg <= 1'b0;
        end
        else
        begin
            stack_reg    <= stack_next;
            level_reg    <= level_next;
            awaiting_reg <= awaiting_next;
        end
    end

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LEVEL_W'(ROOT_LOG))
        else $error("tree level beyond root depth");

    a_value_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && awaiting_reg |=> !awaiting_reg)
        else $error("value phase not left after value byte");

    a_flag_holds_level: assert property (@(posedge clk) disable iff (!rst_n)
        step && !awaiting_reg && (stream_byte == UNIFORM_FLAG)
        |=> awaiting_reg && $stable(level_reg))
        else $error("uniform flag moved the walk");

    a_done_at_root: assert property (@(posedge clk) disable iff (!rst_n)
        fill.valid && fill.done |=> level_reg == '0)
        else $error("image done but walk not back at root");

endmodule

@@ hdl/quadtree_image_decoder.sv @@
// Top level of the quadtree image decoder: input register, walker, result register.
// Depends on qtd_pkg and qtd_walk.
//
// Takes one stream byte per clock when unstalled and returns one fill (row, column, log2 side,
// value) for every value byte, through the input register and then the result register. A new
// byte is accepted in every cycle while the result register drains; the walk state (an 8-entry
// quadrant stack and level) is updated on each step, so throughput is one byte per clock unless
// the result register stalls. IMAGE_SIDE is rounded down to a power of two and capped at 256.
// image_done marks the fill that completes a tree; the next byte starts a new image. A tree
// whose last leaf is a size-one split completes without any fill.
module quadtree_image_decoder
    import qtd_pkg::*;
#(
    parameter int IMAGE_SIDE = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          stream_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          fill_row,
    output logic [7:0]          fill_col,
    output logic [LEVEL_W-1:0]  fill_log_size,
    output logic [7:0]          fill_value,
    output logic                image_done
);

    localparam int RootLog = root_log(IMAGE_SIDE);

    logic       byte_valid_reg;
    logic [7:0] byte_reg;
    logic       step;
    fill_t      fill;
    fill_t      out_reg;
    logic       out_valid_reg;

    assign step     = byte_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !byte_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            byte_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= stream_byte;
        end
    end

    qtd_walk #(
        .ROOT_LOG (RootLog)
    ) u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .stream_byte (byte_reg),
        .fill        (fill)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= fill.valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && fill.valid)
        begin
            out_reg <= fill;
        end
    end

    assign out_valid     = out_valid_reg;
    assign fill_row      = out_reg.row;
    assign fill_col      = out_reg.col;
    assign fill_log_size = out_reg.log_size;
    assign fill_value    = out_reg.value;
    assign image_done    = out_reg.done;

endmodule

@@ test/tb_top.sv @@
// Testbench for quadtree_image_decoder: directed stream table, then random quadtree streams,
// every fill checked against the table or a behavioral walk of the tree. Depends on qtd_pkg and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qtd_pkg::*;

    function automatic int side_log(input int s);
        int n;
        n = 0;
        while (n < STACK_DEPTH && (longint'(2) << n) <= longint'(s))
            n++;
        return n;
    endfunction

    localparam int SIDE        = 256;
    localparam int TREE_LOG    = side_log(SIDE);
    localparam int RAND_BYTES  = 750;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0]         row;
        logic [7:0]         col;
        logic [LEVEL_W-1:0] lsz;
        logic [7:0]         value;
        logic               done;
    } fill_rec_t;

    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        fill_rec_t  f;
    } dir_row_t;

    typedef enum int {SHAPE_SHALLOW, SHAPE_BUSHY, SHAPE_SPINE} shape_t;
    typedef enum int {RX_OPEN, RX_TOGGLE, RX_RANDOM, RX_HOLD} rx_mode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [7:0]          stream_byte = 8'h00;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [7:0]          fill_row;
    logic [7:0]          fill_col;
    logic [LEVEL_W-1:0]  fill_log_size;
    logic [7:0]          fill_value;
    logic                image_done;

    // tree walk state
    quad_t               walk_stack [STACK_DEPTH];
    logic [LEVEL_W-1:0]  walk_level;
    logic                walk_want_value;
    bit                  tree_closed;

    fill_rec_t           fills_due [$];
    dir_row_t            dir_rows [$];
    int                  errors = 0;
    int                  cycles = 0;

    // stream shaping
    shape_t              img_shape;
    quad_t               spine_quad;
    int                  img_bytes;
    int                  noise_left;
    int                  burst_left = 0;

    rx_mode_t            rx_mode = RX_OPEN;
    int                  rx_left = 0;
    fill_rec_t           due;

    quadtree_image_decoder #(.IMAGE_SIDE(SIDE)) dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .stream_byte   (stream_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fill_row      (fill_row),
        .fill_col      (fill_col),
        .fill_log_size (fill_log_size),
        .fill_value    (fill_value),
        .image_done    (image_done)
    );

    always #10 clk = ~clk;

    // Step to the next block in pre-order; 1 when the whole tree has been walked.
    function automatic bit next_block();
        while (walk_level > 0 && walk_stack[walk_level - 1] == QUAD_LAST)
            walk_level--;
        if (walk_level == 0)
            return 1'b1;
        walk_stack[walk_level - 1] = walk_stack[walk_level - 1] + 2'd1;
        return 1'b0;
    endfunction

    task automatic decode_byte(input logic [7:0] b, output bit has_fill, output fill_rec_t f);
        logic [7:0] r;
        logic [7:0] c;
        int         sh;
        has_fill = 1'b0;
        f = '0;
        tree_closed = 1'b0;
        if (walk_want_value)
        begin
            r = 8'h00;
            c = 8'h00;
            for (int d = 0; d < walk_level && d < TREE_LOG; d++)
            begin
                sh = TREE_LOG - 1 - d;
                r[sh] = walk_stack[d][1];
                c[sh] = walk_stack[d][0];
            end
            walk_want_value = 1'b0;
            f.row   = r;
            f.col   = c;
            f.lsz   = LEVEL_W'(TREE_LOG - walk_level);
            f.value = b;
            f.done  = next_block();
            tree_closed = f.done;
            has_fill = 1'b1;
        end
        else if (b == UNIFORM_FLAG)
        begin
            walk_want_value = 1'b1;
        end
        else if (walk_level < TREE_LOG)
        begin
            walk_stack[walk_level] = '0;
            walk_level++;
        end
        else
        begin
            // split of a single pixel: nothing to fill, move on
            tree_closed = next_block();
        end
    endtask

    // Picks the next stream byte from the walk state and the current image shape.
    function automatic logic [7:0] next_stream_byte();
        int         pct;
        bit         path;
        logic [7:0] b;
        if (tree_closed)
        begin
            img_shape  = shape_t'($urandom_range(0, 2));
            spine_quad = quad_t'($urandom_range(0, 3));
            img_bytes  = 0;
        end
        img_bytes++;
        if (walk_want_value)
        begin
            case ($urandom_range(0, 9))
                0: return 8'h00;
                1: return 8'hFF;
                2: return UNIFORM_FLAG;
                default: return 8'($urandom_range(0, 255));
            endcase
        end
        // keep images bounded: only leaves once an image runs long
        if (img_bytes > 150)
            return UNIFORM_FLAG;
        if (noise_left > 0)
        begin
            noise_left--;
            return 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 79) == 0)
            noise_left = $urandom_range(5, 30);
        path = 1'b1;
        for (int d = 0; d < walk_level; d++)
        begin
            if (walk_stack[d] != spine_quad)
                path = 1'b0;
        end
        case (img_shape)
            SHAPE_SHALLOW: pct = 25;
            SHAPE_BUSHY:   pct = 40;
            default:       pct = path ? 100 : 10;
        endcase
        if ($urandom_range(0, 99) >= pct)
            return UNIFORM_FLAG;
        case ($urandom_range(0, 5))
            0: b = 8'h00;
            1: b = 8'hFF;
            default:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == UNIFORM_FLAG);
            end
        endcase
        return b;
    endfunction

    // Bursts of transfers separated by random gaps.
    task automatic put_byte(input logic [7:0] b);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        stream_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic dir_byte(input logic [7:0] b);
        dir_row_t r;
        r = '0;
        r.b = b;
        dir_rows.push_back(r);
    endtask

    task automatic dir_fill(input logic [7:0] b, input logic [7:0] row, input logic [7:0] col,
                            input logic [LEVEL_W-1:0] lsz, input logic done);
        dir_row_t r;
        r.b       = b;
        r.typed   = 1'b1;
        r.f.row   = row;
        r.f.col   = col;
        r.f.lsz   = lsz;
        r.f.value = b;
        r.f.done  = done;
        dir_rows.push_back(r);
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    initial
    begin
        dir_row_t   row;
        bit         has_fill;
        fill_rec_t  pred;
        logic [7:0] b;

        // single-pixel-free whole-image fills at the value extremes
        dir_byte(UNIFORM_FLAG);
        dir_fill(8'h00, 8'd0, 8'd0, 4'd8, 1'b1);
        dir_byte(UNIFORM_FLAG);
        dir_fill(8'hFF, 8'd0, 8'd0, 4'd8, 1'b1);
        // root split, bottom-left split again; last leaf closes the image
        dir_byte(8'h00);
        dir_byte(UNIFORM_FLAG);
        dir_fill(8'h55, 8'd0, 8'd0, 4'd7, 1'b0);
        dir_byte(UNIFORM_FLAG);
        dir_fill(8'hAA, 8'd0, 8'd128, 4'd7, 1'b0);
        dir_byte(8'hFF);
        dir_byte(UNIFORM_FLAG);
        dir_fill(8'h01, 8'd128, 8'd0, 4'd6, 1'b0);
        dir_byte(UNIFORM_FLAG);
        dir_fill(8'h80, 8'd128, 8'd64, 4'd6, 1'b0);
        dir_byte(UNIFORM_FLAG);
        dir_fill(8'h7F, 8'd192, 8'd0, 4'd6, 1'b0);
        dir_byte(UNIFORM_FLAG);
        dir_fill(8'hFE, 8'd192, 8'd64, 4'd6, 1'b0);
        dir_byte(UNIFORM_FLAG);
        dir_fill(8'h10, 8'd128, 8'd128, 4'd7, 1'b1);
        // descend a few levels, leave the image open for the random part
        dir_byte(8'h02);
        dir_byte(8'h04);
        dir_byte(8'h08);
        dir_byte(8'h10);
        dir_byte(UNIFORM_FLAG);
        dir_byte(8'h80);

        for (int i = 0; i < STACK_DEPTH; i++)
            walk_stack[i] = '0;
        walk_level      = '0;
        walk_want_value = 1'b0;
        tree_closed     = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            put_byte(row.b);
            decode_byte(row.b, has_fill, pred);
            if (row.typed)
                fills_due.push_back(row.f);
            else if (has_fill)
                fills_due.push_back(pred);
        end

        img_shape  = SHAPE_SPINE;
        spine_quad = QUAD_LAST;
        img_bytes  = 0;
        noise_left = 0;
        for (int n = 0; n < RAND_BYTES; n++)
        begin
            b = next_stream_byte();
            put_byte(b);
            decode_byte(b, has_fill, pred);
            if (has_fill)
                fills_due.push_back(pred);
        end
        in_valid <= 1'b0;

        while (fills_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("quadtree_image_decoder test passed");
        else
            $display("quadtree_image_decoder test failed");
        $finish;
    end

    // result side: check each transfer, then pick the next stall pattern
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (fills_due.size() == 0)
            begin
                $display("%0t: unexpected fill, expected none actual row %0d col %0d value %0d",
                         $time, fill_row, fill_col, fill_value);
                errors++;
            end
            else
            begin
                due = fills_due.pop_front();
                check_field("fill_row", due.row, fill_row);
                check_field("fill_col", due.col, fill_col);
                check_field("fill_log_size", due.lsz, fill_log_size);
                check_field("fill_value", due.value, fill_value);
                check_field("image_done", due.done, image_done);
            end
        end
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(8, 60);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_TOGGLE: out_ready <= rx_left[0];
            RX_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
            default:   out_ready <= (rx_left < 4);
        endcase
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("quadtree_image_decoder test failed");
            $finish;
        end
    end

endmodule
